/* sv/egcd_pkg.sv */
package egcd_pkg;

  localparam int unsigned OperandWidthDef = 16;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StDiv   = 4'b0100,
    StOut   = 4'b1000
  } egcd_state_e;

endpackage

/* sv/egcd_if.sv */
interface egcd_in_if #(
  parameter int unsigned W = egcd_pkg::OperandWidthDef
);
  logic         valid;
  logic         ready;
  logic [W-1:0] modulus;
  logic [W-1:0] value;

  modport source (output valid, output modulus, output value, input ready);
  modport sink (input valid, input modulus, input value, output ready);
endinterface

interface egcd_out_if #(
  parameter int unsigned W = egcd_pkg::OperandWidthDef
);
  logic                valid;
  logic                ready;
  logic [W-1:0]        divisor;
  logic signed [W-1:0] coefficient;

  modport source (output valid, output divisor, output coefficient, input ready);
  modport sink (input valid, input divisor, input coefficient, output ready);
endinterface

/* sv/extended_gcd_coefficient.sv */
// Extended Euclid: one item at a time, ready only while idle.
// Each Euclid step runs a check state, a division by the divider and an update of the
// remainders and coefficients. At 16 bits there are at most 23 steps. Once the result
// is taken, the block returns to idle and is ready for the next item. Reset is
// asynchronous, active low, and leaves no result pending.
module extended_gcd_coefficient #(
  parameter int unsigned OPERAND_WIDTH = egcd_pkg::OperandWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  egcd_in_if.sink     in_i,
  egcd_out_if.source  out_o
);
  import egcd_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  egcd_state_e state_q, state_d;

  logic [W-1:0]      rp_q, rp_d;
  logic [W-1:0]      rc_q, rc_d;
  logic signed [W:0] cp_q, cp_d;
  logic signed [W:0] cc_q, cc_d;
  logic [W-1:0]        gcd_q, gcd_d;
  logic signed [W-1:0] coef_q, coef_d;

  logic                div_start;
  logic                div_done;
  logic [W-1:0]        div_rem;
  logic signed [W+1:0] div_prod;
  logic signed [W+1:0] co_next;

  egcd_div #(
    .W(W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rp_q),
    .divisor_i  (rc_q),
    .coef_i     (cc_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  // The magnitude of the new coefficient never exceeds modulus / gcd, so it
  // fits one bit wider than the operands.
  assign co_next = {cp_q[W], cp_q} - div_prod;

  always_comb begin
    state_d   = state_q;
    rp_d      = rp_q;
    rc_d      = rc_q;
    cp_d      = cp_q;
    cc_d      = cc_q;
    gcd_d     = gcd_q;
    coef_d    = coef_q;
    div_start = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          rp_d    = in_i.modulus;
          rc_d    = in_i.value;
          cp_d    = '0;
          cc_d    = (W+1)'(1);
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (rc_q == '0) begin
          gcd_d   = rp_q;
          coef_d  = cp_q[W-1:0];
          state_d = StOut;
        end else begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          rp_d    = rc_q;
          rc_d    = div_rem;
          cp_d    = cc_q;
          cc_d    = co_next[W:0];
          state_d = StCheck;
        end
      end
      StOut: begin
        if (out_o.ready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q   <= rp_d;
    rc_q   <= rc_d;
    cp_q   <= cp_d;
    cc_q   <= cc_d;
    gcd_q  <= gcd_d;
    coef_q <= coef_d;
  end

  assign in_i.ready        = (state_q == StIdle);
  assign out_o.valid       = (state_q == StOut);
  assign out_o.divisor     = gcd_q;
  assign out_o.coefficient = coef_q;

endmodule

/* sv/egcd_div.sv */
// Restoring divider, one quotient bit per cycle. Alongside the division it
// builds quotient * coef_i by Horner's rule, so the product is ready when the
// last quotient bit is.
module egcd_div #(
  parameter int unsigned W = egcd_pkg::OperandWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        dividend_i,
  input  logic [W-1:0]        divisor_i,
  input  logic signed [W:0]   coef_i,
  output logic                done_o,
  output logic [W-1:0]        rem_o,
  output logic signed [W+1:0] prod_o
);
  import egcd_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);
  localparam logic [CntW-1:0] CntLoad = CntW'(W);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [W:0]          rem_q, rem_d;
  logic [W-1:0]        dvd_q, dvd_d;
  logic [W-1:0]        dsr_q, dsr_d;
  logic signed [W+1:0] co_q, co_d;
  logic signed [W+1:0] acc_q, acc_d;

  logic [W:0]   rem_shift;
  logic [W+1:0] trial;
  logic         qbit;

  always_comb begin
    rem_shift = {rem_q[W-1:0], dvd_q[W-1]};
    trial     = {1'b0, rem_shift} - {2'b00, dsr_q};
    qbit      = ~trial[W+1];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    co_d   = co_q;
    acc_d  = acc_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntLoad;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      co_d   = {coef_i[W], coef_i};
      acc_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? trial[W:0] : rem_shift;
      dvd_d = {dvd_q[W-2:0], 1'b0};
      acc_d = (acc_q <<< 1) + (qbit ? co_q : '0);
      cnt_d = cnt_q - CntOne;
      if (cnt_q == CntOne) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    co_q  <= co_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[W-1:0];
  assign prod_o = acc_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned W = egcd_pkg::OperandWidthDef;

  typedef struct packed {
    logic [W-1:0]        divisor;
    logic signed [W-1:0] coefficient;
  } bezout_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  egcd_in_if  #(.W(W)) in_if ();
  egcd_out_if #(.W(W)) out_if ();

  extended_gcd_coefficient #(
    .OPERAND_WIDTH(W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk_i = ~clk_i;

  bezout_t awaited_bezout[$];
  int      items_sent = 0;
  int      results_seen = 0;
  int      mismatch_count = 0;
  bit      idling_on = 1'b1;
  int      ready_stall_left = 0;

  // Plain extended Euclid over wide integers; the coefficient always fits W bits.
  function automatic bezout_t compute_bezout(logic [W-1:0] modulus, logic [W-1:0] value);
    longint unsigned rem_prev, rem_cur, rem_next, quo;
    longint          co_prev, co_cur, co_next;
    bezout_t         res;
    rem_prev = longint'(modulus);
    rem_cur  = longint'(value);
    co_prev  = 0;
    co_cur   = 1;
    while (rem_cur != 0) begin
      quo      = rem_prev / rem_cur;
      rem_next = rem_prev - quo * rem_cur;
      co_next  = co_prev - longint'(quo) * co_cur;
      rem_prev = rem_cur;
      rem_cur  = rem_next;
      co_prev  = co_cur;
      co_cur   = co_next;
    end
    res.divisor     = rem_prev[W-1:0];
    res.coefficient = co_prev[W-1:0];
    return res;
  endfunction

  // Leaves valid high after the handshake, so that a following item can follow
  // without a gap; release_input lowers it at the end of a phase.
  task automatic send_item(logic [W-1:0] modulus, logic [W-1:0] value);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      // Half of the gaps start only once the block is idle and waiting.
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (!in_if.ready);
      end
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.modulus <= modulus;
    in_if.value   <= value;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    awaited_bezout.push_back(compute_bezout(modulus, value));
    items_sent++;
  endtask

  task automatic release_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_result(logic [W-1:0] divisor, logic signed [W-1:0] coefficient);
    bezout_t want;
    results_seen++;
    if (awaited_bezout.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: unexpected result divisor=%0d coefficient=%0d", divisor, coefficient);
    end else begin
      want = awaited_bezout.pop_front();
      if (divisor !== want.divisor || coefficient !== want.coefficient) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result %0d: divisor exp %0d got %0d, coefficient exp %0d got %0d",
                   results_seen, want.divisor, divisor, want.coefficient, coefficient);
      end
    end
  endtask

  // Result sink: checks each accepted item and, while idling_on is set, stalls in random bursts.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      check_result(out_if.divisor, out_if.coefficient);
    end
    if (!idling_on) begin
      ready_stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (ready_stall_left > 0) begin
      ready_stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_stall_left = $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic pick_random_operands(output logic [W-1:0] modulus, output logic [W-1:0] value);
    int              kind, k, g;
    longint unsigned fa, fb, ft;
    logic [W-1:0]    tmp;
    kind = $urandom_range(0, 9);
    case (kind)
      4: begin
        modulus = W'($urandom);
        value   = W'($urandom);
        if (value < modulus) begin
          tmp     = value;
          value   = modulus;
          modulus = tmp;
        end
      end
      5: begin
        modulus = W'($urandom_range(0, 31));
        value   = W'($urandom_range(0, 31));
      end
      6: begin
        g       = $urandom_range(1, 255);
        modulus = W'(g * $urandom_range(0, 65535 / g));
        value   = W'(g * $urandom_range(0, 65535 / g));
      end
      7: begin
        // Neighboring Fibonacci numbers give the longest runs of the loop.
        k  = $urandom_range(2, 22);
        fa = 1;
        fb = 1;
        repeat (k) begin
          ft = fa + fb;
          fa = fb;
          fb = ft;
        end
        g = $urandom_range(1, 65535 / int'(fb));
        modulus = W'(fb * g);
        value   = W'(fa * g);
        if ($urandom_range(0, 1) == 1) begin
          tmp     = value;
          value   = modulus;
          modulus = tmp;
        end
      end
      8: begin
        modulus = $urandom_range(0, 1) ? '0 : '1;
        value   = W'($urandom);
        if ($urandom_range(0, 1) == 1) begin
          tmp     = value;
          value   = modulus;
          modulus = tmp;
        end
      end
      9: begin
        modulus = W'($urandom | (1 << (W - 1)));
        value   = W'($urandom);
      end
      default: begin
        modulus = W'($urandom);
        value   = W'($urandom);
      end
    endcase
  endtask

  task automatic wait_until_drained();
    while (awaited_bezout.size() != 0) @(posedge clk_i);
    // Nothing more may come out after the last expected item.
    repeat (450) @(posedge clk_i);
  endtask

  task automatic test_corner_cases();
    send_item(16'd0, 16'd0);
    send_item(16'd0, 16'd5);
    send_item(16'd0, 16'hFFFF);
    send_item(16'd5, 16'd0);
    send_item(16'hFFFF, 16'd0);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'h8000, 16'h8000);
    send_item(16'd1, 16'd1);
    send_item(16'd1, 16'hFFFF);
    send_item(16'hFFFF, 16'd1);
    send_item(16'd7, 16'd12);
    send_item(16'd12, 16'd18);
    send_item(16'd26, 16'd7);
    send_item(16'd65521, 16'd17);
    send_item(16'hFFFF, 16'h8000);
    send_item(16'h5555, 16'hAAAA);
    send_item(16'hAAAA, 16'h5555);
    send_item(16'd46368, 16'd28657);
    send_item(16'd28657, 16'd46368);
    send_item(16'd65535, 16'd40503);
    release_input();
    wait_until_drained();
  endtask

  task automatic test_random_with_idling(int count);
    logic [W-1:0] modulus, value;
    idling_on = 1'b1;
    repeat (count) begin
      pick_random_operands(modulus, value);
      send_item(modulus, value);
    end
    release_input();
    wait_until_drained();
  endtask

  task automatic test_back_to_back(int count);
    logic [W-1:0] modulus, value;
    idling_on = 1'b0;
    repeat (count) begin
      pick_random_operands(modulus, value);
      send_item(modulus, value);
    end
    release_input();
    wait_until_drained();
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.modulus = '0;
    in_if.value   = '0;
    out_if.ready  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_random_with_idling(830);
    test_back_to_back(120);

    $display("Sent %0d items (corner operands, random, shared factors, Fibonacci pairs),",
             items_sent);
    $display("checked %0d results with random stalls on both sides, then without.",
             results_seen);
    if (mismatch_count == 0 && awaited_bezout.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, awaited_bezout.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", awaited_bezout.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
sv/egcd_pkg.sv
sv/egcd_if.sv
sv/egcd_div.sv
sv/extended_gcd_coefficient.sv
tb/sv/testbench.sv
